[rtl/indexed_list_engine_macros.svh]
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Checks that hold in the same cycle as the antecedent.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks on the cycle after the antecedent.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ile_pkg.sv]
package ile_pkg;

   localparam int CMD_BITS      = 3;
   localparam int POS_BITS      = 8;
   localparam int VALUE_BITS    = 32;
   localparam int COUNT_BITS    = 9;
   localparam int STATUS_BITS   = 2;
   localparam int WIDE_BITS     = 64;

   localparam int DEFAULT_CAPACITY  = 256;
   localparam int DEFAULT_WORD_BITS = 32;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_APPEND       = 3'd0,
      CMD_REPLACE      = 3'd1,
      CMD_READ         = 3'd2,
      CMD_REMOVE_SHIFT = 3'd3,
      CMD_REMOVE_SWAP  = 3'd4,
      CMD_REMOVE_EQUAL = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [POS_BITS-1:0]   position;
      logic [VALUE_BITS-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  out_value;
      logic [COUNT_BITS-1:0]  count;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic fill_we;
   } mem_ctl_type;

endpackage

[rtl/ile_req_if.sv]
interface ile_req_if;
   logic                           valid;
   logic                           ready;
   logic [ile_pkg::CMD_BITS-1:0]   cmd;
   logic [ile_pkg::POS_BITS-1:0]   position;
   logic [ile_pkg::VALUE_BITS-1:0] elem_value;

   modport source (output valid, output cmd, output position, output elem_value,
                   input ready);
   modport sink (input valid, input cmd, input position, input elem_value,
                 output ready);
endinterface

[rtl/ile_rsp_if.sv]
interface ile_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ile_pkg::VALUE_BITS-1:0]  out_value;
   logic [ile_pkg::COUNT_BITS-1:0]  count;
   logic [ile_pkg::STATUS_BITS-1:0] status;

   modport source (output valid, output out_value, output count, output status,
                   input ready);
   modport sink (input valid, input out_value, input count, input status,
                 output ready);
endinterface

[rtl/ile_store.sv]
module ile_store #(
   parameter int CAPACITY  = ile_pkg::DEFAULT_CAPACITY,
   parameter int WORD_BITS = ile_pkg::DEFAULT_WORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ile_pkg::mem_ctl_type             mem_ctl,
   input  logic [$clog2(CAPACITY)-1:0]      rd_addr,
   input  logic [$clog2(CAPACITY)-1:0]      wr_addr,
   input  logic [WORD_BITS-1:0]             wr_data,
   input  logic [$clog2(CAPACITY+1)-1:0]    fill_in,
   output logic [WORD_BITS-1:0]             rd_data,
   output logic [$clog2(CAPACITY+1)-1:0]    fill
);

   localparam int FW = $clog2(CAPACITY + 1);

   logic [WORD_BITS-1:0] entries_ff [CAPACITY];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [FW-1:0]        fill_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (mem_ctl.fill_we) begin
         fill_ff <= fill_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

endmodule

[rtl/ile_ctrl.sv]
`include "indexed_list_engine_macros.svh"

module ile_ctrl #(
   parameter int CAPACITY  = ile_pkg::DEFAULT_CAPACITY,
   parameter int WORD_BITS = ile_pkg::DEFAULT_WORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ile_pkg::req_type                 req,
   input  logic                             out_free,
   output logic                             done,
   output ile_pkg::rsp_type                 rsp,
   output ile_pkg::mem_ctl_type             mem_ctl,
   output logic [$clog2(CAPACITY)-1:0]      rd_addr,
   output logic [$clog2(CAPACITY)-1:0]      wr_addr,
   output logic [WORD_BITS-1:0]             wr_data,
   output logic [$clog2(CAPACITY+1)-1:0]    fill_in,
   input  logic [WORD_BITS-1:0]             rd_data,
   input  logic [$clog2(CAPACITY+1)-1:0]    fill
);

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int CW = (FW > ile_pkg::POS_BITS) ? FW : ile_pkg::POS_BITS;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_FETCH    = 6'b000100,
      S_SWAP     = 6'b001000,
      S_WALK     = 6'b010000,
      S_DONE     = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [ile_pkg::CMD_BITS-1:0]    cmd_ff, cmd_in;
   logic [ile_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   logic [WORD_BITS-1:0]            val_ff, val_in;
   logic [WORD_BITS-1:0]            res_ff, res_in;
   logic [ile_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [FW-1:0]                   rd_idx_ff, rd_idx_in;
   logic [FW-1:0]                   wr_idx_ff, wr_idx_in;
   logic                            pend_ff, pend_in;

   logic          bad_pos;
   logic          full;
   logic [FW-1:0] last_idx;

   assign bad_pos  = CW'(pos_ff) >= CW'(fill);
   assign full     = fill == FW'(CAPACITY);
   assign last_idx = fill - FW'(1);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      res_in    = res_ff;
      status_in = status_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      pend_in   = pend_ff;
      mem_ctl   = '0;
      rd_addr   = '0;
      wr_addr   = '0;
      wr_data   = val_ff;
      fill_in   = fill;
      done      = 1'b0;
      req_ready = state_ff == S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req.cmd;
               pos_in    = req.position;
               val_in    = WORD_BITS'(ile_pkg::WIDE_BITS'(req.elem_value));
               res_in    = '0;
               status_in = ile_pkg::ST_OK;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (cmd_ff)
               ile_pkg::CMD_APPEND: begin
                  if (full) begin
                     status_in = ile_pkg::ST_FULL;
                  end else begin
                     mem_ctl.wr_en   = 1'b1;
                     wr_addr         = fill[AW-1:0];
                     mem_ctl.fill_we = 1'b1;
                     fill_in         = fill + FW'(1);
                  end
               end
               ile_pkg::CMD_REPLACE, ile_pkg::CMD_READ, ile_pkg::CMD_REMOVE_SHIFT,
               ile_pkg::CMD_REMOVE_SWAP: begin
                  if (bad_pos) begin
                     status_in = ile_pkg::ST_BAD_POS;
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = AW'(pos_ff);
                     state_in      = S_FETCH;
                  end
               end
               ile_pkg::CMD_REMOVE_EQUAL: begin
                  rd_idx_in = '0;
                  wr_idx_in = '0;
                  pend_in   = 1'b0;
                  state_in  = S_WALK;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FETCH: begin
            res_in   = rd_data;
            state_in = S_DONE;
            case (cmd_ff)
               ile_pkg::CMD_REPLACE: begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = AW'(pos_ff);
               end
               ile_pkg::CMD_REMOVE_SWAP: begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = last_idx[AW-1:0];
                  state_in      = S_SWAP;
               end
               ile_pkg::CMD_REMOVE_SHIFT: begin
                  rd_idx_in = FW'(pos_ff) + FW'(1);
                  wr_idx_in = FW'(pos_ff);
                  pend_in   = 1'b0;
                  state_in  = S_WALK;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SWAP: begin
            // move the last entry into the gap
            mem_ctl.wr_en   = 1'b1;
            wr_addr         = AW'(pos_ff);
            wr_data         = rd_data;
            mem_ctl.fill_we = 1'b1;
            fill_in         = last_idx;
            state_in        = S_DONE;
         end
         S_WALK: begin
            // reads run at least one entry ahead of the compacting write pointer
            if (pend_ff) begin
               if (!(cmd_ff == ile_pkg::CMD_REMOVE_EQUAL && rd_data == val_ff)) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = wr_idx_ff[AW-1:0];
                  wr_data       = rd_data;
                  wr_idx_in     = wr_idx_ff + FW'(1);
               end
            end
            if (rd_idx_ff < fill) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = rd_idx_ff[AW-1:0];
               rd_idx_in     = rd_idx_ff + FW'(1);
               pend_in       = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  mem_ctl.fill_we = 1'b1;
                  fill_in         = wr_idx_ff;
                  state_in        = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp.out_value = ile_pkg::VALUE_BITS'(ile_pkg::WIDE_BITS'(res_ff));
   assign rsp.count     = ile_pkg::COUNT_BITS'(fill);
   assign rsp.status    = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
   end

   `ILE_ASSERT_NOW(a_fill_range, 1'b1, fill <= FW'(CAPACITY), "entry count above capacity")
   `ILE_ASSERT_NOW(a_walk_order, mem_ctl.wr_en && state_ff == S_WALK, wr_idx_ff < rd_idx_ff, "compacting write overtook read")
   `ILE_ASSERT_NEXT(a_accept_dispatch, req_valid && req_ready, state_ff == S_DISPATCH, "accepted request not dispatched")
   `ILE_ASSERT_NEXT(a_done_release, state_ff == S_DONE && out_free, state_ff == S_IDLE, "result handed over but not idle")

endmodule

[rtl/indexed_list_engine.sv]
// Steps: append, bad position and unused commands go from dispatch to done; read and replace
// add a fetch of the entry, and remove-by-swap adds a fetch and a swap of the last entry.
// Shift removal walks the entries after the position and remove-all-equal walks every entry,
// one stored entry per cycle through the single read and single write port of the entry memory.
// One request is in work at a time; the next is taken the cycle after its result is registered.
// Reset empties the list (count zero); entry memory is not cleared and needs no sweep.
module indexed_list_engine #(
   parameter int CAPACITY  = ile_pkg::DEFAULT_CAPACITY,
   parameter int WORD_BITS = ile_pkg::DEFAULT_WORD_BITS
) (
   input logic      clock,
   input logic      reset,
   ile_req_if.sink  req_chan,
   ile_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);

   ile_pkg::req_type     req;
   ile_pkg::rsp_type     rsp_next;
   ile_pkg::rsp_type     rsp_ff;
   ile_pkg::mem_ctl_type mem_ctl;
   logic                 rsp_valid_ff;
   logic                 out_free;
   logic                 done;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;
   logic [FW-1:0]        fill_in;
   logic [FW-1:0]        fill;

   assign req.cmd        = req_chan.cmd;
   assign req.position   = req_chan.position;
   assign req.elem_value = req_chan.elem_value;

   // the result register frees as soon as the sink takes it
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   ile_ctrl #(
      .CAPACITY (CAPACITY),
      .WORD_BITS(WORD_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req      (req),
      .out_free (out_free),
      .done     (done),
      .rsp      (rsp_next),
      .mem_ctl  (mem_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .fill_in  (fill_in),
      .rd_data  (rd_data),
      .fill     (fill)
   );

   ile_store #(
      .CAPACITY (CAPACITY),
      .WORD_BITS(WORD_BITS)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .mem_ctl(mem_ctl),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .fill_in(fill_in),
      .rd_data(rd_data),
      .fill   (fill)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_value = rsp_ff.out_value;
   assign rsp_chan.count     = rsp_ff.count;
   assign rsp_chan.status    = rsp_ff.status;

endmodule
